// ===== hdl/sphere_decoder_lattice_search_defines.svh =====
// Assertion macros shared by the checker of the lattice search block.
// No dependencies; take in with `include before use.
`ifndef SPHERE_DECODER_LATTICE_SEARCH_DEFINES_SVH
`define SPHERE_DECODER_LATTICE_SEARCH_DEFINES_SVH

// same-cycle implication, reset masked
`define SDLS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masked
`define SDLS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/sdls_pkg.sv =====
// Shared types, codes and helpers of the lattice search block.
// No dependencies.
package sdls_pkg;

    localparam logic [2:0] CMD_LOAD_TRI   = 3'd0;
    localparam logic [2:0] CMD_LOAD_TGT   = 3'd1;
    localparam logic [2:0] CMD_LOAD_DIAG  = 3'd2;
    localparam logic [2:0] CMD_LOAD_RECIP = 3'd3;
    localparam logic [2:0] CMD_START      = 3'd4;

    localparam int SUM_W      = 52;
    localparam int COORD_W    = 18;
    localparam int VISIT_W    = 17;
    localparam int RESULT_CAP = 8;
    localparam logic [VISIT_W-1:0] SEARCH_BUDGET = 17'd65536;
    localparam logic [3:0] DIM_RESET = 4'd8;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_START,
        OP_MAC_CLR,
        OP_MUL_R,
        OP_ACC,
        OP_DIFF,
        OP_CMUL,
        OP_CEN,
        OP_RND,
        OP_PD_CLR,
        OP_PD_MUL,
        OP_PD_SQ,
        OP_PD_ACC,
        OP_BEST,
        OP_ADV
    } dp_op_t;

    typedef struct packed {
        logic   load;
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic               z_in_range;
        logic               v_ovf;
        logic               acc_ovf;
        logic               over_radius;
        logic signed [15:0] best_coord;
    } dp_stat_t;

    function automatic logic [31:0] mag32(logic signed [31:0] x);
        return x[31] ? 32'(-x) : 32'(x);
    endfunction

endpackage

// ===== hdl/sdls_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sdls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/sdls_datapath.sv =====
// Datapath of the lattice search: operand stores, matrix RAM, multipliers
// and accumulators. Depends on sdls_pkg and sdls_ram.
module sdls_datapath #(
    parameter int MAX_DIM = 8,
    parameter int VALUE_WIDTH = 32,
    localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
    input  logic               clk,
    input  sdls_pkg::dp_cmd_t  cmd,
    input  logic [IDX_W-1:0]   lvl,
    input  logic [IDX_W-1:0]   elem,
    input  logic [IDX_W-1:0]   sel,
    input  logic [2:0]         in_command,
    input  logic [2:0]         in_row,
    input  logic [2:0]         in_col,
    input  logic [31:0]        in_value,
    output sdls_pkg::dp_stat_t stat
);

    localparam int VW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
    localparam int CW = sdls_pkg::COORD_W;
    localparam int SW = sdls_pkg::SUM_W;

    logic signed [31:0]    target_reg [MAX_DIM];
    logic signed [31:0]    diag_reg   [MAX_DIM];
    logic signed [31:0]    recip_reg  [MAX_DIM];
    logic signed [CW-1:0]  cur_reg    [MAX_DIM];
    logic signed [CW-1:0]  step_reg   [MAX_DIM];
    logic signed [31:0]    center_reg [MAX_DIM];
    logic signed [15:0]    best_reg   [MAX_DIM];
    logic [63:0]           radius_reg;
    logic signed [SW-1:0]  sum_reg;
    logic signed [47:0]    prod_reg;
    logic signed [31:0]    d_reg;
    logic [63:0]           m_reg;
    logic                  neg_reg;
    logic [64:0]           p_reg;
    logic [63:0]           t_reg;
    logic [63:0]           s_reg;

    logic signed [31:0]    ld_val;
    logic                  row_ok;
    logic                  col_ok;
    logic [IDX_W-1:0]      row_ix;
    logic [IDX_W-1:0]      col_ix;
    logic                  ram_we;
    logic [31:0]           ram_rdata;

    logic signed [15:0]    z_i;
    logic signed [47:0]    mul_r;
    logic signed [SW:0]    dfull;
    logic [SW-31:0]        dhi;
    logic signed [31:0]    dsat;
    logic [64:0]           q_sum;
    logic [48:0]           q;
    logic [31:0]           cq;
    logic signed [31:0]    cval;
    logic signed [31:0]    c_k;
    logic [32:0]           r_sum;
    logic [16:0]           rq;
    logic signed [CW-1:0]  coord;
    logic signed [CW-1:0]  step;
    logic signed [32:0]    diff;
    logic [32:0]           dmag;
    logic [65:0]           v_sum;
    logic [49:0]           v;
    logic signed [CW-1:0]  st_k;

    assign ld_val = 32'(signed'(in_value[VW-1:0]));
    assign row_ok = (32'(in_row) < MAX_DIM);
    assign col_ok = (32'(in_col) < MAX_DIM);
    assign row_ix = IDX_W'(in_row);
    assign col_ix = IDX_W'(in_col);
    assign ram_we = cmd.load && (in_command == sdls_pkg::CMD_LOAD_TRI) && row_ok && col_ok;

    sdls_ram #(
        .WIDTH (32),
        .DEPTH (1 << (2 * IDX_W))
    ) u_tri (
        .clk   (clk),
        .we    (ram_we),
        .waddr ({row_ix, col_ix}),
        .wdata (ld_val),
        .raddr ({elem, lvl}),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        z_i   = cur_reg[elem][15:0];
        mul_r = $signed(ram_rdata) * z_i;

        // saturate the residual to 32 bits
        dfull = (SW+1)'(target_reg[lvl]) - (SW+1)'(sum_reg);
        dhi   = dfull[SW:31];
        if (!dfull[SW] && (|dhi))
            dsat = 32'sh7fffffff;
        else if (dfull[SW] && !(&dhi))
            dsat = 32'sh80000000;
        else
            dsat = dfull[31:0];

        q_sum = 65'(m_reg) + 65'h8000;
        q     = q_sum[64:16];
        if (neg_reg)
        begin
            cq   = (q > 49'h80000000) ? 32'h80000000 : q[31:0];
            cval = 32'(-$signed(cq));
        end
        else
        begin
            cq   = (q > 49'h7fffffff) ? 32'h7fffffff : q[31:0];
            cval = $signed(cq);
        end

        c_k   = center_reg[lvl];
        r_sum = 33'(sdls_pkg::mag32(c_k)) + 33'h8000;
        rq    = r_sum[32:16];
        if (c_k[31])
            coord = -$signed(CW'(rq));
        else
            coord = (rq > 17'd32767) ? CW'(32767) : $signed(CW'(rq));
        step = ((34)'(c_k) < $signed({coord, 16'b0})) ? -CW'(1) : CW'(1);

        diff = 33'(signed'({z_i, 16'b0})) - 33'(center_reg[elem]);
        dmag = diff[32] ? 33'(-diff) : 33'(diff);

        v_sum = 66'(p_reg) + 66'h8000;
        v     = v_sum[65:16];

        st_k = step_reg[lvl];

        stat.z_in_range  = (cur_reg[lvl][CW-1:15] == 3'b000) ||
                           (cur_reg[lvl][CW-1:15] == 3'b111);
        stat.v_ovf       = |v[49:32];
        stat.acc_ovf     = (s_reg > ~t_reg);
        stat.over_radius = (s_reg > radius_reg);
        stat.best_coord  = best_reg[sel];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && row_ok)
        begin
            case (in_command)
                sdls_pkg::CMD_LOAD_TGT:   target_reg[row_ix] <= ld_val;
                sdls_pkg::CMD_LOAD_DIAG:  diag_reg[row_ix]   <= ld_val;
                sdls_pkg::CMD_LOAD_RECIP: recip_reg[row_ix]  <= ld_val;
                default: ;
            endcase
        end
        case (cmd.op)
            sdls_pkg::OP_START:
            begin
                for (int j = 0; j < MAX_DIM; j++)
                    best_reg[j] <= '0;
                radius_reg <= '1;
            end
            sdls_pkg::OP_MAC_CLR: sum_reg  <= '0;
            sdls_pkg::OP_MUL_R:   prod_reg <= mul_r;
            sdls_pkg::OP_ACC:     sum_reg  <= sum_reg + SW'(prod_reg);
            sdls_pkg::OP_DIFF:    d_reg    <= dsat;
            sdls_pkg::OP_CMUL:
            begin
                m_reg   <= 64'(sdls_pkg::mag32(d_reg)) * 64'(sdls_pkg::mag32(recip_reg[lvl]));
                neg_reg <= d_reg[31] ^ recip_reg[lvl][31];
            end
            sdls_pkg::OP_CEN:     center_reg[lvl] <= cval;
            sdls_pkg::OP_RND:
            begin
                cur_reg[lvl]  <= coord;
                step_reg[lvl] <= step;
            end
            sdls_pkg::OP_PD_CLR:  s_reg <= '0;
            sdls_pkg::OP_PD_MUL:  p_reg <= 65'(sdls_pkg::mag32(diag_reg[elem])) * 65'(dmag);
            sdls_pkg::OP_PD_SQ:   t_reg <= 64'(v[31:0]) * 64'(v[31:0]);
            sdls_pkg::OP_PD_ACC:  s_reg <= s_reg + t_reg;
            sdls_pkg::OP_BEST:
            begin
                for (int j = 0; j < MAX_DIM; j++)
                    best_reg[j] <= cur_reg[j][15:0];
                radius_reg <= s_reg;
            end
            sdls_pkg::OP_ADV:
            begin
                cur_reg[lvl]  <= cur_reg[lvl] + st_k;
                step_reg[lvl] <= st_k[CW-1] ? (-st_k + CW'(1)) : (-st_k - CW'(1));
            end
            default: ;
        endcase
    end

endmodule

// ===== hdl/sdls_ctrl.sv =====
// Controller of the lattice search: sequencing state machine, level and
// element counters, dimension register and result register. Uses sdls_pkg.
module sdls_ctrl #(
    parameter int MAX_DIM = 8,
    localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
    localparam int CNT_W = IDX_W + 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         in_command,
    input  logic               dimension_we,
    input  logic [3:0]         dimension_wdata,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_index,
    output logic [15:0]        m_coord,
    output logic               m_last,
    output sdls_pkg::dp_cmd_t  cmd,
    output logic [IDX_W-1:0]   lvl,
    output logic [IDX_W-1:0]   elem,
    output logic [IDX_W-1:0]   sel,
    input  sdls_pkg::dp_stat_t stat
);

    localparam int CAP = (MAX_DIM < sdls_pkg::RESULT_CAP) ? MAX_DIM : sdls_pkg::RESULT_CAP;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_LS_INIT = 4'd1;
    localparam logic [3:0] S_LS_RD   = 4'd2;
    localparam logic [3:0] S_LS_MUL  = 4'd3;
    localparam logic [3:0] S_LS_ACC  = 4'd4;
    localparam logic [3:0] S_LS_DIFF = 4'd5;
    localparam logic [3:0] S_LS_CMUL = 4'd6;
    localparam logic [3:0] S_LS_CEN  = 4'd7;
    localparam logic [3:0] S_LS_RND  = 4'd8;
    localparam logic [3:0] S_EVAL    = 4'd9;
    localparam logic [3:0] S_PD_MUL  = 4'd10;
    localparam logic [3:0] S_PD_SQ   = 4'd11;
    localparam logic [3:0] S_PD_ACC  = 4'd12;
    localparam logic [3:0] S_DECIDE  = 4'd13;
    localparam logic [3:0] S_ADV     = 4'd14;
    localparam logic [3:0] S_OUT     = 4'd15;

    logic [3:0]                   state_reg, state_next;
    logic [IDX_W-1:0]             k_reg, k_next;
    logic [CNT_W-1:0]             i_reg, i_next;
    logic [CNT_W-1:0]             j_reg, j_next;
    logic [CNT_W-1:0]             n_reg, n_next;
    logic [sdls_pkg::VISIT_W-1:0] visits_reg, visits_next;
    logic [3:0]                   dim_reg;
    logic                         valid_reg, valid_next;
    logic [2:0]                   index_reg, index_next;
    logic [15:0]                  coord_reg, coord_next;
    logic                         last_reg, last_next;

    logic [CNT_W-1:0] n_act;
    logic [CNT_W-1:0] k_up;
    logic [CNT_W-1:0] i_up;
    logic             top_lvl;
    logic             prune;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = valid_reg;
    assign m_index = index_reg;
    assign m_coord = coord_reg;
    assign m_last  = last_reg;
    assign lvl     = k_reg;
    assign elem    = i_reg[IDX_W-1:0];
    assign sel     = j_reg[IDX_W-1:0];

    always_comb
    begin
        if (dim_reg == 4'd0)
            n_act = CNT_W'(1);
        else if (32'(dim_reg) > CAP)
            n_act = CNT_W'(CAP);
        else
            n_act = CNT_W'(dim_reg);

        k_up    = {1'b0, k_reg} + CNT_W'(1);
        i_up    = i_reg + CNT_W'(1);
        top_lvl = ({1'b0, k_reg} == n_reg - CNT_W'(1));
        prune   = 1'b0;

        state_next  = state_reg;
        k_next      = k_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        n_next      = n_reg;
        visits_next = visits_reg;
        cmd.load    = 1'b0;
        cmd.op      = sdls_pkg::OP_NONE;

        valid_next = valid_reg && !m_ready;
        index_next = index_reg;
        coord_next = coord_reg;
        last_next  = last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_command == sdls_pkg::CMD_START)
                    begin
                        cmd.op      = sdls_pkg::OP_START;
                        n_next      = n_act;
                        k_next      = IDX_W'(n_act - CNT_W'(1));
                        visits_next = '0;
                        state_next  = S_LS_INIT;
                    end
                end
            end
            S_LS_INIT:
            begin
                cmd.op = sdls_pkg::OP_MAC_CLR;
                i_next = k_up;
                state_next = (k_up < n_reg) ? S_LS_RD : S_LS_DIFF;
            end
            S_LS_RD:   state_next = S_LS_MUL;
            S_LS_MUL:
            begin
                cmd.op     = sdls_pkg::OP_MUL_R;
                state_next = S_LS_ACC;
            end
            S_LS_ACC:
            begin
                cmd.op     = sdls_pkg::OP_ACC;
                i_next     = i_up;
                state_next = (i_up < n_reg) ? S_LS_RD : S_LS_DIFF;
            end
            S_LS_DIFF:
            begin
                cmd.op     = sdls_pkg::OP_DIFF;
                state_next = S_LS_CMUL;
            end
            S_LS_CMUL:
            begin
                cmd.op     = sdls_pkg::OP_CMUL;
                state_next = S_LS_CEN;
            end
            S_LS_CEN:
            begin
                cmd.op     = sdls_pkg::OP_CEN;
                state_next = S_LS_RND;
            end
            S_LS_RND:
            begin
                cmd.op     = sdls_pkg::OP_RND;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (visits_reg >= sdls_pkg::SEARCH_BUDGET)
                begin
                    j_next     = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    visits_next = visits_reg + sdls_pkg::VISIT_W'(1);
                    cmd.op      = sdls_pkg::OP_PD_CLR;
                    i_next      = {1'b0, k_reg};
                    if (!stat.z_in_range)
                        prune = 1'b1;
                    else
                        state_next = S_PD_MUL;
                end
            end
            S_PD_MUL:
            begin
                cmd.op     = sdls_pkg::OP_PD_MUL;
                state_next = S_PD_SQ;
            end
            S_PD_SQ:
            begin
                if (stat.v_ovf)
                    prune = 1'b1;
                else
                begin
                    cmd.op     = sdls_pkg::OP_PD_SQ;
                    state_next = S_PD_ACC;
                end
            end
            S_PD_ACC:
            begin
                if (stat.acc_ovf)
                    prune = 1'b1;
                else
                begin
                    cmd.op     = sdls_pkg::OP_PD_ACC;
                    i_next     = i_up;
                    state_next = (i_up < n_reg) ? S_PD_MUL : S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.over_radius)
                    prune = 1'b1;
                else if (k_reg != '0)
                begin
                    k_next     = k_reg - IDX_W'(1);
                    state_next = S_LS_INIT;
                end
                else
                begin
                    // new best point: record it, then climb as for a prune
                    cmd.op = sdls_pkg::OP_BEST;
                    prune  = 1'b1;
                end
            end
            S_ADV:
            begin
                cmd.op     = sdls_pkg::OP_ADV;
                state_next = S_EVAL;
            end
            S_OUT:
            begin
                if (!valid_reg || m_ready)
                begin
                    valid_next = 1'b1;
                    index_next = 3'(j_reg);
                    coord_next = stat.best_coord;
                    last_next  = (j_reg == n_reg - CNT_W'(1));
                    j_next     = j_reg + CNT_W'(1);
                    if (j_reg == n_reg - CNT_W'(1))
                        state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // climb one level and step to the next zigzag candidate, or end the search at the top level
        if (prune)
        begin
            if (top_lvl)
            begin
                j_next     = '0;
                state_next = S_OUT;
            end
            else
            begin
                k_next     = k_up[IDX_W-1:0];
                state_next = S_ADV;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            k_reg      <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            n_reg      <= '0;
            visits_reg <= '0;
            dim_reg    <= sdls_pkg::DIM_RESET;
            valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            k_reg      <= k_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            n_reg      <= n_next;
            visits_reg <= visits_next;
            valid_reg  <= valid_next;
            if (dimension_we)
                dim_reg <= dimension_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        index_reg <= index_next;
        coord_reg <= coord_next;
        last_reg  <= last_next;
    end

endmodule

// ===== hdl/sphere_decoder_lattice_search.sv =====
// Top level of the closest-lattice-point search block.
// Depends on sdls_pkg, sdls_ctrl, sdls_datapath and sdls_ram.
//
// Load transactions (matrix entry, target, diagonal, reciprocal diagonal) are
// taken one per cycle. A start transaction runs a depth-first zigzag search
// and then returns one result per solution element, one per cycle while the
// sink is ready, tlast on the final one. The search time depends on the data:
// entering level k runs a multiply-accumulate over the levels above it, each
// candidate at level k a partial distance over levels k to n-1, and the count
// of candidates is capped at 65536. All of this runs through one shared
// set of multipliers sequenced by the controller, and the block takes no new
// transaction until the last result of the search has been issued.
module sphere_decoder_lattice_search #(
    parameter int MAX_DIM = 8,
    parameter int VALUE_WIDTH = 32,
    localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // row_index, col_index, load_value, zero pad
    input  logic [2:0]  s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // element_index, lattice_coord, zero pad
    output logic        m_axis_tlast,
    input  logic        dimension_we,
    input  logic [3:0]  dimension_wdata
);

    sdls_pkg::dp_cmd_t  cmd;
    sdls_pkg::dp_stat_t stat;
    logic [IDX_W-1:0]   lvl;
    logic [IDX_W-1:0]   elem;
    logic [IDX_W-1:0]   sel;
    logic [2:0]         m_index;
    logic [15:0]        m_coord;

    sdls_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_valid         (s_axis_tvalid),
        .s_ready         (s_axis_tready),
        .in_command      (s_axis_tuser),
        .dimension_we    (dimension_we),
        .dimension_wdata (dimension_wdata),
        .m_valid         (m_axis_tvalid),
        .m_ready         (m_axis_tready),
        .m_index         (m_index),
        .m_coord         (m_coord),
        .m_last          (m_axis_tlast),
        .cmd             (cmd),
        .lvl             (lvl),
        .elem            (elem),
        .sel             (sel),
        .stat            (stat)
    );

    sdls_datapath #(
        .MAX_DIM     (MAX_DIM),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk        (clk),
        .cmd        (cmd),
        .lvl        (lvl),
        .elem       (elem),
        .sel        (sel),
        .in_command (s_axis_tuser),
        .in_row     (s_axis_tdata[2:0]),
        .in_col     (s_axis_tdata[5:3]),
        .in_value   (s_axis_tdata[37:6]),
        .stat       (stat)
    );

    assign m_axis_tdata = {5'b0, m_coord, m_index};

endmodule

// ===== hdl/sdls_checker.sv =====
// Port-level checker of the lattice search block, bound to the top level.
// Depends on sdls_pkg and sphere_decoder_lattice_search_defines.svh.
`include "sphere_decoder_lattice_search_defines.svh"

module sdls_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [39:0] s_axis_tdata,
    input logic [2:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        dimension_we,
    input logic [3:0]  dimension_wdata
);

    logic [1:0] owed_reg;
    logic [2:0] exp_idx_reg;
    logic       start_acc;
    logic       out_acc;
    logic       out_stall;
    logic [24:0] out_word;

    assign start_acc = s_axis_tvalid && s_axis_tready && (s_axis_tuser == sdls_pkg::CMD_START);
    assign out_acc   = m_axis_tvalid && m_axis_tready;
    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign out_word  = {m_axis_tlast, m_axis_tdata};

    // count starts still owed results and track which index comes next
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owed_reg    <= 2'd0;
            exp_idx_reg <= 3'd0;
        end
        else
        begin
            case ({start_acc, out_acc && m_axis_tlast})
                2'b10:   owed_reg <= owed_reg + 2'd1;
                2'b01:   owed_reg <= owed_reg - 2'd1;
                default: owed_reg <= owed_reg;
            endcase
            if (out_acc)
                exp_idx_reg <= m_axis_tlast ? 3'd0 : (m_axis_tdata[2:0] + 3'd1);
        end
    end

    `SDLS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall,
        m_axis_tvalid && $stable(out_word), "result changed while stalled")
    `SDLS_ASSERT_IMPL(a_out_owed, clk, rst_n, m_axis_tvalid, owed_reg != 2'd0,
        "result without a start")
    `SDLS_ASSERT_IMPL(a_out_order, clk, rst_n, m_axis_tvalid,
        m_axis_tdata[2:0] == exp_idx_reg, "result index out of order")
    `SDLS_ASSERT_NEXT(a_busy, clk, rst_n, start_acc, !s_axis_tready,
        "transaction taken during search")

endmodule

bind sphere_decoder_lattice_search sdls_checker u_sdls_checker (.*);
